>>> design/assert_macros.svh
// assertion macros shared by the escape-time design files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked property check, off while reset is held
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

// condition that must never be seen at a clock edge
`define ASSERT_NEVER(label, expr, msg) \
    `ASSERT_CLK(label, !(expr), msg)

`endif

>>> design/mbe_pkg.sv
// shared types, constants and helpers for the escape-time evaluator
`timescale 1ns / 1ps

package mbe_pkg;

    // number formats
    localparam int FRAC_BITS  = 28;
    localparam int COORD_BITS = 12;
    localparam int ITER_BITS  = 16;
    localparam int FIX_W      = 32;

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    // cardioid test widths
    localparam int CARD_G     = (FRAC_BITS < 28) ? FRAC_BITS : 28;
    localparam int CARD_SHIFT = FRAC_BITS - CARD_G;
    localparam int XQ_W       = CARD_G + 3;
    localparam int Y_W        = CARD_G + 2;
    localparam int SQ_W       = 2 * XQ_W;
    localparam int Y2_W       = 2 * Y_W;
    localparam int Q_W        = CARD_G + 3;
    localparam int QX_W       = CARD_G + 4;
    localparam int LHS_W      = Q_W + QX_W;

    // saturation helper input width
    localparam int SAT_IN_W   = FIX_W + COORD_BITS + 4;

    // queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // signed range limits
    localparam longint FIX_MAX_L = (longint'(1) << (FIX_W - 1)) - 1;
    localparam longint FIX_MIN_L = -(longint'(1) << (FIX_W - 1));
    localparam logic signed [SAT_IN_W-1:0] SAT_HI = SAT_IN_W'(FIX_MAX_L);
    localparam logic signed [SAT_IN_W-1:0] SAT_LO = SAT_IN_W'(FIX_MIN_L);

    // register reset values
    localparam logic [FIX_W-1:0]     RST_REAL_ORIGIN = FIX_W'(-64'sd536870912);
    localparam logic [FIX_W-1:0]     RST_IMAG_ORIGIN = FIX_W'(-64'sd268435456);
    localparam logic [FIX_W-1:0]     RST_REAL_STEP   = FIX_W'(64'sd1006633);
    localparam logic [FIX_W-1:0]     RST_IMAG_STEP   = FIX_W'(64'sd894785);
    localparam logic [ITER_BITS-1:0] RST_MAX_ITER    = ITER_BITS'(64);

    // register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_REAL_ORIGIN = 3'd0,
        CFG_IMAG_ORIGIN = 3'd1,
        CFG_REAL_STEP   = 3'd2,
        CFG_IMAG_STEP   = 3'd3,
        CFG_MAX_ITER    = 3'd4
    } t_cfg_reg;

    // register file contents
    typedef struct packed {
        logic [FIX_W-1:0]     real_origin;
        logic [FIX_W-1:0]     imag_origin;
        logic [FIX_W-1:0]     real_step;
        logic [FIX_W-1:0]     imag_step;
        logic [ITER_BITS-1:0] max_iter;
    } t_cfg;

    // input item
    typedef struct packed {
        logic [COORD_BITS-1:0] pixel_x;
        logic [COORD_BITS-1:0] pixel_y;
    } t_pix_in;

    // result item
    typedef struct packed {
        logic [ITER_BITS-1:0]  iter_count;
        logic [COORD_BITS-1:0] out_x;
        logic [COORD_BITS-1:0] out_y;
    } t_pix_out;

    // classified point handed from front to back
    typedef struct packed {
        logic [COORD_BITS-1:0] pixel_x;
        logic [COORD_BITS-1:0] pixel_y;
        logic [FIX_W-1:0]      c_re;
        logic [FIX_W-1:0]      c_im;
        logic                  in_card;
    } t_job;

    // front sequencer
    typedef enum logic [2:0] {
        F_IDLE,
        F_PROD,
        F_MAP,
        F_SQR,
        F_SUM,
        F_MUL,
        F_PUSH
    } t_front_state;

    // back sequencer
    typedef enum logic [1:0] {
        B_IDLE,
        B_MUL,
        B_STEP,
        B_RES
    } t_back_state;

    // clamp a wide signed value to the fixed-point range
    function automatic logic [FIX_W-1:0] sat_fix(input logic signed [SAT_IN_W-1:0] v);
        logic [FIX_W-1:0] res;
        if (v > SAT_HI) begin
            res = SAT_HI[FIX_W-1:0];
        end else if (v < SAT_LO) begin
            res = SAT_LO[FIX_W-1:0];
        end else begin
            res = v[FIX_W-1:0];
        end
        return res;
    endfunction

endpackage

>>> design/mbe_front.sv
// front end: maps a pixel to c and runs the main-cardioid test
`timescale 1ns / 1ps
`include "assert_macros.svh"

module mbe_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  mbe_pkg::t_cfg     i_cfg,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  mbe_pkg::t_pix_in  i_in_data,
    output logic              o_push,
    input  logic              i_full,
    output mbe_pkg::t_job     o_job
);
    import mbe_pkg::*;

    localparam int PROD_W = FIX_W + COORD_BITS + 1;
    localparam logic signed [FIX_W-1:0] CARD_ONE     = FIX_W'(longint'(1) << CARD_G);
    localparam logic signed [XQ_W-1:0]  CARD_QUARTER = XQ_W'(longint'(1) << (CARD_G - 2));

    t_front_state r_state, n_state;

    logic [COORD_BITS-1:0]          r_px, r_py;
    logic signed [PROD_W-1:0]       r_prod_re, r_prod_im;
    logic [FIX_W-1:0]               r_c_re, r_c_im;
    logic                           r_in_range;
    logic signed [XQ_W-1:0]         r_xq;
    logic [SQ_W-1:0]                r_xq2;
    logic [Y2_W-1:0]                r_y2;
    logic signed [Q_W-1:0]          r_q;
    logic signed [QX_W-1:0]         r_qx;
    logic [Y2_W-1:0]                r_rhs;
    logic signed [LHS_W-1:0]        r_lhs;

    logic signed [FIX_W-1:0]        w_x, w_y;
    logic signed [XQ_W-1:0]         w_xq;
    logic signed [Y_W-1:0]          w_y_t;
    logic [SQ_W-1:0]                w_sq_sum;
    logic                           w_inside;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            F_IDLE: if (i_in_valid) n_state = F_PROD;
            F_PROD: n_state = F_MAP;
            F_MAP:  n_state = F_SQR;
            F_SQR:  n_state = F_SUM;
            F_SUM:  n_state = F_MUL;
            F_MUL:  n_state = F_PUSH;
            F_PUSH: if (!i_full) n_state = F_IDLE;
            default: n_state = F_IDLE;
        endcase
    end

    // handshake outputs
    always_comb begin
        o_in_stall = (r_state != F_IDLE);
        o_push     = (r_state == F_PUSH) && !i_full;
    end

    // cardioid coordinates taken from the mapped point
    always_comb begin
        w_x      = $signed(r_c_re) >>> CARD_SHIFT;
        w_y      = $signed(r_c_im) >>> CARD_SHIFT;
        w_xq     = XQ_W'(w_x) - CARD_QUARTER;
        w_y_t    = Y_W'(w_y);
        w_sq_sum = r_xq2 + SQ_W'(r_y2);
        w_inside = r_in_range && (r_lhs < $signed(LHS_W'(r_rhs)));
    end

    // datapath, one stage per state
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            F_IDLE: begin
                if (i_in_valid) begin
                    r_px <= i_in_data.pixel_x;
                    r_py <= i_in_data.pixel_y;
                end
            end
            F_PROD: begin
                r_prod_re <= PROD_W'($signed({1'b0, r_px})) * PROD_W'($signed(i_cfg.real_step));
                r_prod_im <= PROD_W'($signed({1'b0, r_py})) * PROD_W'($signed(i_cfg.imag_step));
            end
            F_MAP: begin
                r_c_re <= sat_fix(SAT_IN_W'($signed(i_cfg.real_origin)) + SAT_IN_W'(r_prod_re));
                r_c_im <= sat_fix(SAT_IN_W'($signed(i_cfg.imag_origin)) + SAT_IN_W'(r_prod_im));
            end
            F_SQR: begin
                r_in_range <= (w_x >= -CARD_ONE) && (w_x <= CARD_ONE) &&
                              (w_y >= -CARD_ONE) && (w_y <= CARD_ONE);
                r_xq  <= w_xq;
                r_xq2 <= SQ_W'(w_xq) * SQ_W'(w_xq);
                r_y2  <= Y2_W'(w_y_t) * Y2_W'(w_y_t);
            end
            F_SUM: begin
                r_q   <= $signed(Q_W'(w_sq_sum >> CARD_G));
                r_qx  <= QX_W'($signed(Q_W'(w_sq_sum >> CARD_G))) + QX_W'(r_xq);
                r_rhs <= (r_y2 + Y2_W'(3)) >> 2;
            end
            F_MUL: begin
                r_lhs <= LHS_W'(r_q) * LHS_W'(r_qx);
            end
            default: begin
            end
        endcase
    end

    // classified point
    assign o_job = '{pixel_x: r_px, pixel_y: r_py, c_re: r_c_re, c_im: r_c_im,
                     in_card: w_inside};

    `ASSERT_CLK(a_accept_starts, (i_in_valid && !o_in_stall) |=> (r_state == F_PROD), "front did not start after transfer")
    `ASSERT_CLK(a_hold_when_full, (r_state == F_PUSH && i_full) |=> (r_state == F_PUSH), "front left push while queue full")

endmodule

>>> design/mbe_queue.sv
// short queue of classified points between front and back
`timescale 1ns / 1ps
`include "assert_macros.svh"

module mbe_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  mbe_pkg::t_job i_data,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_empty,
    output mbe_pkg::t_job o_data
);
    import mbe_pkg::*;

    t_job              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [QCNT_W-1:0] r_count;
    logic              w_wr, w_rd;

    // status and read port
    always_comb begin
        o_full  = (r_count == QCNT_W'(QUEUE_DEPTH));
        o_empty = (r_count == '0);
        w_wr    = i_push && !o_full;
        w_rd    = i_pop && !o_empty;
        o_data  = r_mem[r_rd_ptr];
    end

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_wr) begin
                r_wr_ptr <= (r_wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + QPTR_W'(1);
            end
            if (w_rd) begin
                r_rd_ptr <= (r_rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + QPTR_W'(1);
            end
            if (w_wr && !w_rd) begin
                r_count <= r_count + QCNT_W'(1);
            end else if (w_rd && !w_wr) begin
                r_count <= r_count - QCNT_W'(1);
            end
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    `ASSERT_NEVER(a_no_overflow, i_push && o_full, "push into full queue")
    `ASSERT_NEVER(a_no_underflow, i_pop && o_empty, "pop from empty queue")

endmodule

>>> design/mbe_back.sv
// back end: escape-time iteration and result register
`timescale 1ns / 1ps
`include "assert_macros.svh"

module mbe_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  mbe_pkg::t_cfg     i_cfg,
    input  mbe_pkg::t_job     i_job,
    input  logic              i_empty,
    output logic              o_pop,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output mbe_pkg::t_pix_out o_out_data
);
    import mbe_pkg::*;

    localparam logic [2*FIX_W-1:0] MAG_LIMIT = (2*FIX_W)'(1) << (2*FRAC_BITS + 2);

    t_back_state r_state, n_state;

    logic [ITER_BITS-1:0]      r_count;
    logic [FIX_W-1:0]          r_zr, r_zi, r_cr, r_ci;
    logic [COORD_BITS-1:0]     r_px, r_py;
    logic signed [2*FIX_W-1:0] r_rr, r_ii, r_ri;
    t_pix_out                  r_out;
    logic                      r_out_valid;

    logic                      w_limit;
    logic                      w_escape;
    logic                      w_out_free;
    logic                      w_load_out;
    logic [2*FIX_W-1:0]        w_mag;
    logic signed [2*FIX_W-1:0] w_diff;
    logic [FIX_W-1:0]          w_nr, w_ni;

    // loop conditions and the next z
    always_comb begin
        w_limit    = (r_count >= i_cfg.max_iter);
        w_mag      = $unsigned(r_rr) + $unsigned(r_ii);
        w_escape   = (w_mag >= MAG_LIMIT);
        w_diff     = r_rr - r_ii;
        w_nr       = sat_fix(SAT_IN_W'(w_diff >>> FRAC_BITS) + SAT_IN_W'($signed(r_cr)));
        w_ni       = sat_fix(SAT_IN_W'(r_ri >>> (FRAC_BITS - 1)) + SAT_IN_W'($signed(r_ci)));
        w_out_free = !r_out_valid || !i_out_stall;
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= B_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            B_IDLE: begin
                if (!i_empty) n_state = i_job.in_card ? B_RES : B_MUL;
            end
            B_MUL:  n_state = w_limit ? B_RES : B_STEP;
            B_STEP: n_state = w_escape ? B_RES : B_MUL;
            B_RES:  if (w_out_free) n_state = B_IDLE;
            default: n_state = B_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb begin
        o_pop      = (r_state == B_IDLE) && !i_empty;
        w_load_out = (r_state == B_RES) && w_out_free;
    end

    // iteration datapath
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            B_IDLE: begin
                if (!i_empty) begin
                    r_px    <= i_job.pixel_x;
                    r_py    <= i_job.pixel_y;
                    r_cr    <= i_job.c_re;
                    r_ci    <= i_job.c_im;
                    r_zr    <= i_job.c_re;
                    r_zi    <= i_job.c_im;
                    r_count <= i_job.in_card ? i_cfg.max_iter : '0;
                end
            end
            B_MUL: begin
                r_rr <= (2*FIX_W)'($signed(r_zr)) * (2*FIX_W)'($signed(r_zr));
                r_ii <= (2*FIX_W)'($signed(r_zi)) * (2*FIX_W)'($signed(r_zi));
                r_ri <= (2*FIX_W)'($signed(r_zr)) * (2*FIX_W)'($signed(r_zi));
            end
            B_STEP: begin
                if (!w_escape) begin
                    r_zr    <= w_nr;
                    r_zi    <= w_ni;
                    r_count <= r_count + ITER_BITS'(1);
                end
            end
            default: begin
            end
        endcase
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load_out) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load_out) begin
            r_out <= '{iter_count: r_count, out_x: r_px, out_y: r_py};
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    `ASSERT_CLK(a_count_below_limit, (r_state == B_STEP) |-> (r_count < i_cfg.max_iter), "iteration past the limit")

endmodule

>>> design/mandelbrot_escape_time.sv
// top level of the escape-time evaluator with cardioid check
`timescale 1ns / 1ps
//
// channel  direction  handshake               payload
// in       input      i_in_valid / o_in_stall  i_in_data  (pixel_x, pixel_y)
// out      output     o_out_valid / i_out_stall o_out_data (iter_count, out_x, out_y)
// cfg      input      i_cfg_wr_en             i_cfg_index, i_cfg_wdata
//
// the front takes one pixel at a time (map, cardioid products, push) and stalls
// its input until that pixel is pushed; a full queue holds the push
// each back iteration is a multiply, then an update and escape test; a pixel
// stays in the back until it escapes or reaches the limit, and cardioid points skip the loop
// synchronous active-low reset returns registers to defaults and empties the queue
// a stalled result holds in the output register while the queue keeps the front busy
//
module mandelbrot_escape_time (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_wr_en,
    input  logic [mbe_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [mbe_pkg::CFG_DATA_W-1:0]     i_cfg_wdata,
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  mbe_pkg::t_pix_in                   i_in_data,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output mbe_pkg::t_pix_out                  o_out_data
);
    import mbe_pkg::*;

    t_cfg r_cfg;
    t_job w_push_job, w_pop_job;
    logic w_push, w_full, w_pop, w_empty;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.real_origin <= RST_REAL_ORIGIN;
            r_cfg.imag_origin <= RST_IMAG_ORIGIN;
            r_cfg.real_step   <= RST_REAL_STEP;
            r_cfg.imag_step   <= RST_IMAG_STEP;
            r_cfg.max_iter    <= RST_MAX_ITER;
        end else if (i_cfg_wr_en) begin
            unique case (t_cfg_reg'(i_cfg_index))
                CFG_REAL_ORIGIN: r_cfg.real_origin <= i_cfg_wdata[FIX_W-1:0];
                CFG_IMAG_ORIGIN: r_cfg.imag_origin <= i_cfg_wdata[FIX_W-1:0];
                CFG_REAL_STEP:   r_cfg.real_step   <= i_cfg_wdata[FIX_W-1:0];
                CFG_IMAG_STEP:   r_cfg.imag_step   <= i_cfg_wdata[FIX_W-1:0];
                CFG_MAX_ITER:    r_cfg.max_iter    <= i_cfg_wdata[ITER_BITS-1:0];
                default: begin
                end
            endcase
        end
    end

    // pixel mapping and classification
    mbe_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_data  (i_in_data),
        .o_push     (w_push),
        .i_full     (w_full),
        .o_job      (w_push_job)
    );

    // decoupling queue
    mbe_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_push_job),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_empty (w_empty),
        .o_data  (w_pop_job)
    );

    // iteration and result
    mbe_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_job       (w_pop_job),
        .i_empty     (w_empty),
        .o_pop       (w_pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

endmodule

>>> verif/testbench.sv
// self-checking testbench for the escape-time evaluator with cardioid check
`timescale 1ns / 1ps

module testbench;
    import mbe_pkg::*;

    localparam longint CYCLE_LIMIT  = 4_000_000;
    localparam int     RAND_PHASES  = 14;
    localparam int     PHASE_ITEMS  = 100;
    localparam int     LONG_HOLD    = 400;
    localparam int     TAIL_CYCLES  = 60;
    localparam int     SPARE_LO     = int'(CFG_MAX_ITER) + 1;
    localparam int     SPARE_HI     = (1 << CFG_IDX_W) - 1;
    localparam int     MAX_REPORTS  = 100;

    // expected escape counts, kept in transfer order
    class escape_scoreboard;
        t_pix_out    pending_results[$];
        int          errors;
        longint      re_org;
        longint      im_org;
        longint      re_stp;
        longint      im_stp;
        int unsigned iter_limit;

        function new();
            errors     = 0;
            re_org     = longint'(signed'(RST_REAL_ORIGIN));
            im_org     = longint'(signed'(RST_IMAG_ORIGIN));
            re_stp     = longint'(signed'(RST_REAL_STEP));
            im_stp     = longint'(signed'(RST_IMAG_STEP));
            iter_limit = 32'(RST_MAX_ITER);
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
            case (idx)
                CFG_REAL_ORIGIN: re_org = longint'(signed'(d[FIX_W-1:0]));
                CFG_IMAG_ORIGIN: im_org = longint'(signed'(d[FIX_W-1:0]));
                CFG_REAL_STEP:   re_stp = longint'(signed'(d[FIX_W-1:0]));
                CFG_IMAG_STEP:   im_stp = longint'(signed'(d[FIX_W-1:0]));
                CFG_MAX_ITER:    iter_limit = 32'(d[ITER_BITS-1:0]);
                default: ;
            endcase
        endfunction

        function longint clamp_fix(longint v);
            if (v > FIX_MAX_L) return FIX_MAX_L;
            if (v < FIX_MIN_L) return FIX_MIN_L;
            return v;
        endfunction

        // quartic main-cardioid test on the truncated point
        function bit in_main_cardioid(longint cr, longint ci);
            longint x, y, unit, xq, y2, q, lhs;
            x    = cr >>> CARD_SHIFT;
            y    = ci >>> CARD_SHIFT;
            unit = longint'(1) << CARD_G;
            if ((x < 0 ? -x : x) > unit || (y < 0 ? -y : y) > unit) return 1'b0;
            xq  = x - (longint'(1) << (CARD_G - 2));
            y2  = y * y;
            q   = (xq * xq + y2) >>> CARD_G;
            lhs = q * (q + xq);
            return lhs < ((y2 + 3) >>> 2);
        endfunction

        function int unsigned escape_count(longint cr, longint ci);
            longint      zr, zi, nr, ni;
            logic [63:0] mag;
            logic [63:0] bound;
            int unsigned n;
            bound = 64'd4 << FRAC_BITS;
            zr    = cr;
            zi    = ci;
            n     = 0;
            while (n < iter_limit) begin
                mag = $unsigned(zr * zr) + $unsigned(zi * zi);
                if ((mag >> FRAC_BITS) >= bound) break;
                nr = ((zr * zr - zi * zi) >>> FRAC_BITS) + cr;
                ni = ((zr * zi) >>> (FRAC_BITS - 1)) + ci;
                zr = clamp_fix(nr);
                zi = clamp_fix(ni);
                n++;
            end
            return n;
        endfunction

        function void note_pixel(t_pix_in p);
            t_pix_out    res;
            longint      cr, ci;
            int unsigned n;
            cr = clamp_fix(re_org + longint'(p.pixel_x) * re_stp);
            ci = clamp_fix(im_org + longint'(p.pixel_y) * im_stp);
            n  = in_main_cardioid(cr, ci) ? iter_limit : escape_count(cr, ci);
            res.iter_count = n[ITER_BITS-1:0];
            res.out_x      = p.pixel_x;
            res.out_y      = p.pixel_y;
            pending_results.push_back(res);
        endfunction

        function void flag_field(string name, longint want, longint got);
            if (want != got) begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("%0t mismatch %s: expected %0d, actual %0d", $time, name, want, got);
            end
        endfunction

        function void check_result(t_pix_out got);
            t_pix_out want;
            if (pending_results.size() == 0) begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("%0t unexpected result: expected none, actual count %0d x %0d y %0d",
                             $time, got.iter_count, got.out_x, got.out_y);
                return;
            end
            want = pending_results.pop_front();
            flag_field("iter_count", want.iter_count, got.iter_count);
            flag_field("out_x", want.out_x, got.out_x);
            flag_field("out_y", want.out_y, got.out_y);
        endfunction
    endclass

    logic                  clk        = 1'b0;
    logic                  rst_n      = 1'b0;
    logic                  cfg_wr_en  = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index  = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata  = '0;
    logic                  in_valid   = 1'b0;
    t_pix_in               in_data    = '0;
    logic                  out_stall  = 1'b0;
    logic                  in_stall;
    logic                  out_valid;
    t_pix_out              out_data;

    escape_scoreboard board = new();
    bit     idle_on    = 1'b1;
    bit     hold_armed = 1'b0;
    longint cycle_count = 0;

    mandelbrot_escape_time DUT (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_wr_en (cfg_wr_en),
        .i_cfg_index (cfg_index),
        .i_cfg_wdata (cfg_wdata),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // run limit
    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("testbench: errors");
            $finish;
        end
    end

    // result transfers
    always @(posedge clk) begin
        if (rst_n && out_valid && !out_stall) begin
            board.check_result(out_data);
        end
    end

    // receiver back-pressure: random bursts and one long hold
    initial begin : receiver
        int burst;
        forever begin
            if (hold_armed) begin
                hold_armed = 1'b0;
                out_stall <= 1'b1;
                repeat (LONG_HOLD) @(posedge clk);
            end else if (idle_on && $urandom_range(0, 5) == 0) begin
                burst = $urandom_range(1, 12);
                out_stall <= 1'b1;
                repeat (burst) @(posedge clk);
            end else begin
                out_stall <= 1'b0;
                @(posedge clk);
            end
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] d);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= d;
        board.write_reg(idx, d);
        @(posedge clk);
    endtask

    // whole register set, with an occasional write to an unused index
    task automatic set_view(input logic [31:0] ro, io, rs, ims, input logic [15:0] lim);
        write_reg(CFG_REAL_ORIGIN, ro);
        write_reg(CFG_IMAG_ORIGIN, io);
        write_reg(CFG_REAL_STEP, rs);
        write_reg(CFG_IMAG_STEP, ims);
        write_reg(CFG_MAX_ITER, {16'($urandom), lim});
        if ($urandom_range(0, 2) == 0)
            write_reg(CFG_IDX_W'($urandom_range(SPARE_LO, SPARE_HI)), $urandom);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic send_pixel(input logic [COORD_BITS-1:0] px, py);
        t_pix_in item;
        int      gap;
        item.pixel_x = px;
        item.pixel_y = py;
        if (idle_on && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 12);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= item;
        do @(posedge clk); while (in_stall);
        board.note_pixel(item);
    endtask

    // sender waits until every expected result has come back
    task automatic drain();
        in_valid <= 1'b0;
        while (board.pending_results.size() != 0) @(posedge clk);
    endtask

    function automatic logic [31:0] pick_extreme();
        case ($urandom_range(0, 3))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'h0;
            default: return $urandom;
        endcase
    endfunction

    initial begin : stimulus
        int          kind;
        bit          last;
        logic [31:0] ro, io, rs, ims;
        logic [15:0] lim;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset view: corners, cardioid centre, period-two bulb, bit patterns
        send_pixel(12'd0, 12'd0);
        send_pixel(12'd4095, 12'd4095);
        send_pixel(12'd0, 12'd4095);
        send_pixel(12'd4095, 12'd0);
        send_pixel(12'd533, 12'd300);
        send_pixel(12'd267, 12'd300);
        send_pixel(12'hAAA, 12'h555);
        send_pixel(12'h555, 12'hAAA);
        send_pixel(12'd700, 12'd300);
        drain();

        // saturated point, escapes at once
        set_view(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 16'hFFFF);
        write_reg(CFG_IDX_W'(SPARE_HI), 32'hFFFF_FFFF);
        cfg_wr_en <= 1'b0;
        send_pixel(12'd0, 12'd0);
        send_pixel(12'd4095, 12'd4095);
        send_pixel(12'd1, 12'd0);
        drain();

        // zero limit
        set_view(-32'sd536870912, -32'sd268435456, 32'sd1006633, 32'sd894785, 16'd0);
        send_pixel(12'd533, 12'd300);
        send_pixel(12'd4095, 12'd0);
        drain();

        // full limit: bulb point never escapes, cardioid point exits early
        set_view(-32'sd268435456, 32'd0, 32'sd67108864, 32'd0, 16'hFFFF);
        send_pixel(12'd0, 12'd9);
        send_pixel(12'd4, 12'd4095);
        send_pixel(12'd7, 12'd100);
        drain();

        // negative steps with the smallest non-zero limit
        set_view(32'sd134217728, 32'd0, -32'sd1048576, -32'sd524288, 16'd1);
        send_pixel(12'd0, 12'd0);
        send_pixel(12'd4095, 12'd4095);
        send_pixel(12'd100, 12'd200);
        drain();

        // random views
        for (int p = 0; p < RAND_PHASES; p++) begin
            last = (p == RAND_PHASES - 1);
            kind = (p < 4) ? p : $urandom_range(0, 3);
            if (last) kind = 0;
            idle_on = !last && ($urandom_range(0, 3) != 0);
            case (kind)
                0: begin
                    ro  = 32'(-671088640 + int'($urandom_range(0, 1 << 28)));
                    io  = 32'(-536870912 + int'($urandom_range(0, 1 << 28)));
                    rs  = $urandom_range(1 << 17, 1 << 19);
                    ims = $urandom_range(1 << 17, 1 << 19);
                    lim = 16'($urandom_range(1, 80));
                end
                1: begin
                    ro  = 32'(-201326592 + int'($urandom_range(0, 1 << 20)));
                    io  = 32'(26843546 + int'($urandom_range(0, 1 << 20)));
                    rs  = $urandom_range(1, 1 << 12);
                    ims = $urandom_range(1, 1 << 12);
                    lim = 16'($urandom_range(1, 120));
                end
                2: begin
                    ro  = $urandom;
                    io  = $urandom;
                    rs  = $urandom;
                    ims = $urandom;
                    lim = 16'($urandom_range(0, 200));
                end
                default: begin
                    ro  = pick_extreme();
                    io  = pick_extreme();
                    rs  = pick_extreme();
                    ims = pick_extreme();
                    lim = 16'($urandom_range(0, 50));
                end
            endcase
            set_view(ro, io, rs, ims, lim);
            if (p == 0) hold_armed = 1'b1;
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                if ($urandom_range(0, 1) == 0)
                    send_pixel(COORD_BITS'($urandom_range(0, 4095)),
                               COORD_BITS'($urandom_range(0, 4095)));
                else
                    send_pixel(COORD_BITS'($urandom_range(0, 1023)),
                               COORD_BITS'($urandom_range(0, 767)));
            end
            drain();
        end

        repeat (TAIL_CYCLES) @(posedge clk);
        if (board.errors == 0) begin
            $display("testbench: clean");
        end else begin
            $display("testbench: errors");
        end
        $finish;
    end

endmodule
